FILE: src/ftd_pkg.sv
// ----------------------------------------------------------------------------
// ftd_pkg: shared types and constants for the FLV tag deframer
// Holds the parse phase codes, the result kind codes and the fixed lengths and
// type codes of the FLV container.
// ----------------------------------------------------------------------------
package ftd_pkg;

  // Parse phase codes (plain vector state)
  localparam logic [2:0] PH_FILE  = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_PRE   = 3'd2;
  localparam logic [2:0] PH_PAY   = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  // Container layout
  localparam int unsigned CountW      = 24;
  localparam logic [CountW:0] FileHdrLen = 25'd13;
  localparam logic [CountW:0] TagHdrLen  = 25'd11;
  localparam logic [CountW:0] TrailLen   = 25'd4;
  localparam logic [CountW-1:0] FlagsPos = 24'd4;

  localparam logic [7:0] TypeVideo = 8'd9;
  localparam logic [7:0] TypeAudio = 8'd8;
  localparam logic [2:0] PreVideo  = 3'd5;
  localparam logic [2:0] PreAudio  = 3'd2;

  localparam logic [7:0] FrameTypeMask = 8'hF0;
  localparam logic [7:0] FrameTypeKey  = 8'h10;

endpackage

FILE: src/flv_tag_deframer.sv
// ----------------------------------------------------------------------------
// flv_tag_deframer: byte-serial FLV tag demultiplexer
// Parses the file header and the tag headers and emits audio and video
// payload bytes tagged with stream, timestamp, keyframe and last-byte mark.
// ----------------------------------------------------------------------------
// The block takes one FLV byte per cycle and never stalls on its own: every
// accepted byte is parsed in the same cycle by short logic on the parse state
// registers, and any result lands in a single output register, so a new byte
// is taken each cycle while the output side keeps up (throughput one item per
// cycle). in_stall_o rises only while a result is held in
// the output register and the output side stalls it. The 13-byte file header
// is consumed first; bit 0 and bit 2 of its flags byte are reported on every
// result as video_present_o and audio_present_o. Each tag then gives one
// result per payload byte (last_byte_o on the final one), one empty-packet
// result when the payload is empty, or one malformed result when an audio or
// video tag is shorter than its preamble. Other tag types, preamble bytes,
// tag headers and the trailing previous-tag-size are dropped silently. The
// signature and version are not checked.
// ----------------------------------------------------------------------------
module flv_tag_deframer
  import ftd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        stream_index_o,
  output logic [31:0] pts_o,
  output logic        keyframe_o,
  output logic        last_byte_o,
  output logic        video_present_o,
  output logic        audio_present_o
);

  // Parse state
  logic [2:0]        phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        tag_kind_q, tag_kind_d;
  logic [CountW-1:0] tag_size_q, tag_size_d;
  logic [31:0]       tag_time_q, tag_time_d;
  logic              key_q, key_d;
  logic              video_q, video_d;
  logic              audio_q, audio_d;

  // Result register
  logic              out_valid_q;
  kind_e             kind_q;
  logic [7:0]        data_q;
  logic              stream_q;
  logic [31:0]       pts_q;
  logic              keyframe_q;
  logic              last_q;
  logic              vid_pres_q;
  logic              aud_pres_q;

  logic              in_acc;
  logic              emit;
  kind_e             emit_kind;
  logic [7:0]        emit_data;
  logic              emit_last;

  logic [CountW:0]   count_inc;
  logic [2:0]        pre_len;
  logic [CountW-1:0] pre_len_w;
  logic [CountW-1:0] pay_len;
  logic              is_av;

  // Hold the input while a result waits on a stalled output
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign count_inc = {1'b0, count_q} + {{CountW{1'b0}}, 1'b1};
  assign pre_len   = (tag_kind_q == TypeVideo) ? PreVideo : PreAudio;
  assign pre_len_w = {{(CountW-3){1'b0}}, pre_len};
  assign pay_len   = tag_size_q - pre_len_w;
  assign is_av     = (tag_kind_q == TypeVideo) || (tag_kind_q == TypeAudio);

  // Next-state and result logic for one byte
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_inc[CountW-1:0];
    tag_kind_d = tag_kind_q;
    tag_size_d = tag_size_q;
    tag_time_d = tag_time_q;
    key_d      = key_q;
    video_d    = video_q;
    audio_d    = audio_q;
    emit       = 1'b0;
    emit_kind  = KIND_PAYLOAD;
    emit_data  = 8'd0;
    emit_last  = 1'b0;

    unique case (phase_q)
      PH_FILE: begin
        if (count_q == FlagsPos) begin
          video_d = byte_in_i[0];
          audio_d = byte_in_i[2];
        end
        if (count_inc >= FileHdrLen) begin
          count_d = '0;
          phase_d = PH_TAG;
        end
      end
      PH_TAG: begin
        // Capture type, size, timestamp and extension; ignore stream id
        if (count_q == '0) begin
          tag_kind_d = byte_in_i;
          tag_size_d = '0;
          tag_time_d = '0;
          key_d      = 1'b0;
        end else if (count_q <= 24'd3) begin
          tag_size_d = {tag_size_q[CountW-9:0], byte_in_i};
        end else if (count_q <= 24'd6) begin
          tag_time_d = {8'd0, tag_time_q[15:0], byte_in_i};
        end else if (count_q == 24'd7) begin
          tag_time_d = {byte_in_i, tag_time_q[23:0]};
        end
        if (count_inc >= TagHdrLen) begin
          count_d = '0;
          if (is_av && (tag_size_q < pre_len_w)) begin
            // Short tag: report and skip its bytes
            emit      = 1'b1;
            emit_kind = KIND_MALFORMED;
            phase_d   = (tag_size_q != '0) ? PH_SKIP : PH_TRAIL;
          end else if (is_av) begin
            phase_d = PH_PRE;
          end else begin
            phase_d = (tag_size_q != '0) ? PH_SKIP : PH_TRAIL;
          end
        end
      end
      PH_PRE: begin
        if ((count_q == '0) && (tag_kind_q == TypeVideo)) begin
          key_d = ((byte_in_i & FrameTypeMask) == FrameTypeKey);
        end
        if (count_inc >= {1'b0, pre_len_w}) begin
          count_d = '0;
          if (tag_size_q == pre_len_w) begin
            emit      = 1'b1;
            emit_kind = KIND_EMPTY;
            emit_last = 1'b1;
            phase_d   = PH_TRAIL;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        emit      = 1'b1;
        emit_kind = KIND_PAYLOAD;
        emit_data = byte_in_i;
        emit_last = (count_inc >= {1'b0, pay_len});
        if (emit_last) begin
          count_d = '0;
          phase_d = PH_TRAIL;
        end
      end
      PH_SKIP: begin
        if (count_inc >= {1'b0, tag_size_q}) begin
          count_d = '0;
          phase_d = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (count_inc >= TrailLen) begin
          count_d = '0;
          phase_d = PH_TAG;
        end
      end
      default: begin
        // Unreachable code: drop the byte and restart at a tag header
        count_d = '0;
        phase_d = PH_TAG;
      end
    endcase
  end

  // Parse state registers: advance only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FILE;
      count_q    <= '0;
      tag_kind_q <= '0;
      tag_size_q <= '0;
      tag_time_q <= '0;
      key_q      <= 1'b0;
      video_q    <= 1'b0;
      audio_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      tag_kind_q <= tag_kind_d;
      tag_size_q <= tag_size_d;
      tag_time_q <= tag_time_d;
      key_q      <= key_d;
      video_q    <= video_d;
      audio_q    <= audio_d;
    end
  end

  // Output valid: load on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold while stalled (the input is stalled then too)
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      kind_q     <= emit_kind;
      data_q     <= emit_data;
      stream_q   <= (tag_kind_d == TypeAudio);
      pts_q      <= tag_time_d;
      keyframe_q <= (emit_kind == KIND_MALFORMED) ? 1'b0 : key_d;
      last_q     <= emit_last;
      vid_pres_q <= video_d;
      aud_pres_q <= audio_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign stream_index_o  = stream_q;
  assign pts_o           = pts_q;
  assign keyframe_o      = keyframe_q;
  assign last_byte_o     = last_q;
  assign video_present_o = vid_pres_q;
  assign audio_present_o = aud_pres_q;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the FLV tag deframer
// Streams one FLV file through the byte channel: the file header, directed
// video, audio, empty, short and foreign tags, backpressure and drain phases,
// then a long random stream of well-formed tags mixed with desynchronizing
// noise. A byte-level parser in the bench predicts every result, and each
// result taken from the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import ftd_pkg::*;

  localparam int unsigned Limit      = 1_500_000;
  localparam int unsigned RandBytes  = 900;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 8;
  localparam logic [7:0]  TypeScript = 8'd18;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        stream;
    logic [31:0] pts;
    logic        key;
    logic        is_last;
    logic        vpres;
    logic        apres;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_in_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        stream_index_o;
  logic [31:0] pts_o;
  logic        keyframe_o;
  logic        last_byte_o;
  logic        video_present_o;
  logic        audio_present_o;

  flv_tag_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_in_i       (byte_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .stream_index_o  (stream_index_o),
    .pts_o           (pts_o),
    .keyframe_o      (keyframe_o),
    .last_byte_o     (last_byte_o),
    .video_present_o (video_present_o),
    .audio_present_o (audio_present_o)
  );

  always #6 clk_i = ~clk_i;

  // Parser state mirrored by the bench
  logic [2:0]  ph_q    = PH_FILE;
  logic [23:0] cnt_q   = '0;
  logic [7:0]  tkind_q = '0;
  logic [23:0] tsize_q = '0;
  logic [31:0] ttime_q = '0;
  logic        key_q   = 1'b0;
  logic        vid_q   = 1'b0;
  logic        aud_q   = 1'b0;

  frame_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   cycle_cnt  = 0;
  logic          quiet      = 1'b0;   // no idling on either side while set
  logic          hold_req   = 1'b0;   // toggle to start a long receiver hold-off
  logic          hold_ack   = 1'b0;
  int unsigned   hold_left  = 0;

  function automatic logic [23:0] preamble_len();
    return (tkind_q == TypeVideo) ? 24'(PreVideo) : 24'(PreAudio);
  endfunction

  function automatic frame_result_t tag_result(kind_e k, logic [7:0] d, logic l);
    frame_result_t r;
    r.kind    = k;
    r.data    = d;
    r.stream  = (tkind_q == TypeAudio);
    r.pts     = ttime_q;
    r.key     = (k == KIND_MALFORMED) ? 1'b0 : key_q;
    r.is_last = l;
    r.vpres   = vid_q;
    r.apres   = aud_q;
    return r;
  endfunction

  function automatic string fmt_result(frame_result_t r);
    return $sformatf("kind=%0d data=%02h stream=%0d pts=%08h key=%0d last=%0d vp=%0d ap=%0d",
                     r.kind, r.data, r.stream, r.pts, r.key, r.is_last, r.vpres, r.apres);
  endfunction

  // Advance the mirrored parser by one accepted byte; queue any result it yields.
  task automatic deframe_byte(input logic [7:0] b);
    logic [23:0] pay_len;
    case (ph_q)
      PH_FILE: begin
        if (cnt_q == FlagsPos) begin
          vid_q = b[0];
          aud_q = b[2];
        end
        cnt_q = cnt_q + 24'd1;
        if ({1'b0, cnt_q} >= FileHdrLen) begin
          cnt_q = '0;
          ph_q  = PH_TAG;
        end
      end
      PH_TAG: begin
        if (cnt_q == 24'd0) begin
          tkind_q = b;
          tsize_q = '0;
          ttime_q = '0;
          key_q   = 1'b0;
        end else if (cnt_q <= 24'd3) begin
          tsize_q = {tsize_q[15:0], b};
        end else if (cnt_q <= 24'd6) begin
          ttime_q = {8'h00, ttime_q[15:0], b};
        end else if (cnt_q == 24'd7) begin
          ttime_q[31:24] = b;
        end
        cnt_q = cnt_q + 24'd1;
        if ({1'b0, cnt_q} >= TagHdrLen) begin
          cnt_q = '0;
          if ((tkind_q == TypeVideo || tkind_q == TypeAudio) && tsize_q >= preamble_len()) begin
            ph_q = PH_PRE;
          end else begin
            // short audio or video tag: report it, then skip it like a foreign tag
            if (tkind_q == TypeVideo || tkind_q == TypeAudio) begin
              pending_results.push_back(tag_result(KIND_MALFORMED, 8'h00, 1'b0));
            end
            ph_q = (tsize_q != 24'd0) ? PH_SKIP : PH_TRAIL;
          end
        end
      end
      PH_PRE: begin
        if (cnt_q == 24'd0 && tkind_q == TypeVideo) begin
          key_q = ((b & FrameTypeMask) == FrameTypeKey);
        end
        cnt_q = cnt_q + 24'd1;
        if (cnt_q >= preamble_len()) begin
          cnt_q = '0;
          if (tsize_q == preamble_len()) begin
            pending_results.push_back(tag_result(KIND_EMPTY, 8'h00, 1'b1));
            ph_q = PH_TRAIL;
          end else begin
            ph_q = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        pay_len = tsize_q - preamble_len();
        cnt_q   = cnt_q + 24'd1;
        pending_results.push_back(tag_result(KIND_PAYLOAD, b, cnt_q >= pay_len));
        if (cnt_q >= pay_len) begin
          cnt_q = '0;
          ph_q  = PH_TRAIL;
        end
      end
      PH_SKIP: begin
        cnt_q = cnt_q + 24'd1;
        if (cnt_q >= tsize_q) begin
          cnt_q = '0;
          ph_q  = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        cnt_q = cnt_q + 24'd1;
        if ({1'b0, cnt_q} >= TrailLen) begin
          cnt_q = '0;
          ph_q  = PH_TAG;
        end
      end
      default: begin
        cnt_q = '0;
        ph_q  = PH_TAG;
      end
    endcase
  endtask

  // Offer one byte, with random gaps ahead of it, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Send one complete tag: header, size body bytes, previous-tag-size.
  task automatic send_tag(input logic [7:0] ttype, input logic [23:0] size,
                          input logic [31:0] ts, input logic [7:0] lead);
    int unsigned i;
    send_byte(ttype);
    send_byte(size[23:16]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
    send_byte(ts[23:16]);
    send_byte(ts[15:8]);
    send_byte(ts[7:0]);
    send_byte(ts[31:24]);
    repeat (3) send_byte(8'($urandom));
    for (i = 0; i < size; i++) begin
      send_byte((i == 0) ? lead : 8'($urandom));
    end
    repeat (4) send_byte(8'($urandom));
  endtask

  // Random bytes that may land anywhere in a tag; keep the upper size bytes
  // at zero so a misread size stays short, and stop on a tag boundary.
  task automatic send_noise(input int unsigned n);
    int unsigned i;
    logic [7:0]  b;
    i = 0;
    while (i < n || !(ph_q == PH_TAG && cnt_q == 24'd0)) begin
      b = 8'($urandom);
      if (ph_q == PH_TAG && (cnt_q == 24'd1 || cnt_q == 24'd2)) b = 8'h00;
      send_byte(b);
      i++;
    end
  endtask

  // Lower valid and hold the sender until every queued result has come out.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic int unsigned pick_payload_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(12);
    if (r < 97) return $urandom_range(64, 13);
    return $urandom_range(300, 200);
  endfunction

  function automatic logic [7:0] pick_lead();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(99) < 40) b[7:4] = FrameTypeKey[7:4];
    return b;
  endfunction

  task automatic send_random_tag();
    int unsigned r;
    logic [7:0]  t;
    r = $urandom_range(99);
    if (r < 40) begin
      send_tag(TypeVideo, 24'(PreVideo) + 24'(pick_payload_len()), $urandom, pick_lead());
    end else if (r < 70) begin
      send_tag(TypeAudio, 24'(PreAudio) + 24'(pick_payload_len()), $urandom, 8'($urandom));
    end else if (r < 78) begin
      t = 8'($urandom);
      if (t == TypeVideo || t == TypeAudio) t = t + 8'd2;
      send_tag(t, 24'($urandom_range(20)), $urandom, 8'($urandom));
    end else if (r < 88) begin
      if ($urandom_range(1)) send_tag(TypeVideo, 24'($urandom_range(4)), $urandom, pick_lead());
      else send_tag(TypeAudio, 24'($urandom_range(1)), $urandom, 8'($urandom));
    end else begin
      send_noise($urandom_range(20, 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Signature, version, flags, header offset and first previous-tag-size.
  task automatic test_file_header();
    send_byte(8'h46);
    send_byte(8'h4C);
    send_byte(8'h56);
    send_byte(8'h01);
    send_byte(8'($urandom));
    repeat (8) send_byte(8'($urandom));
  endtask

  // Keyframe and interframe video, audio, timestamps at both extremes.
  task automatic test_av_tags();
    send_tag(TypeVideo, 24'(PreVideo) + 24'd3, 32'hFFFF_FFFF, 8'h17);
    send_tag(TypeVideo, 24'(PreVideo) + 24'd1, 32'h0000_0000, 8'h27);
    send_tag(TypeAudio, 24'(PreAudio) + 24'd2, 32'h80FF_00A5, 8'hFF);
  endtask

  // Size equal to the preamble: one empty-packet result each.
  task automatic test_empty_payload();
    send_tag(TypeVideo, 24'(PreVideo), 32'h1234_5678, 8'h1F);
    send_tag(TypeAudio, 24'(PreAudio), 32'hFF00_0001, 8'h00);
  endtask

  // Tags shorter than their preamble, down to zero size.
  task automatic test_short_tags();
    send_tag(TypeVideo, 24'(PreVideo) - 24'd1, 32'hDEAD_BEEF, 8'h17);
    send_tag(TypeVideo, 24'd0, 32'h0102_0304, 8'h17);
    send_tag(TypeAudio, 24'(PreAudio) - 24'd1, 32'hFFFF_FFFF, 8'hFF);
    send_tag(TypeAudio, 24'd0, 32'h0000_0000, 8'h00);
  endtask

  // Foreign tag types are skipped; one skip needs both lower size bytes.
  task automatic test_other_types();
    send_tag(8'h00, 24'd0, 32'h0000_0001, 8'h00);
    send_tag(8'hFF, 24'd3, 32'hFFFF_FFFF, 8'hFF);
    send_tag(TypeScript, 24'h00_01_01, $urandom, 8'($urandom));
  endtask

  // Stall the receiver for a long stretch while bytes keep coming, so the
  // output register fills and the input stalls.
  task automatic test_backpressure();
    hold_req = ~hold_req;
    send_tag(TypeVideo, 24'(PreVideo) + 24'd120, $urandom, 8'h17);
    send_tag(TypeAudio, 24'(PreAudio) + 24'd40, $urandom, 8'($urandom));
  endtask

  // Let the output side drain completely before the stream resumes.
  task automatic test_drain_pause();
    send_tag(TypeAudio, 24'(PreAudio) + 24'd6, $urandom, 8'($urandom));
    pause_until_drained();
    send_tag(TypeVideo, 24'(PreVideo) + 24'd4, $urandom, pick_lead());
    pause_until_drained();
  endtask

  // Mostly well-formed tags with random content, some noise that shifts the
  // tag boundaries; the first stretch runs without idling on either side.
  task automatic test_random_stream();
    int unsigned start;
    start = bytes_sent;
    quiet = 1'b1;
    while (bytes_sent - start < RandBytes) begin
      if (bytes_sent - start >= 300) quiet = 1'b0;
      send_random_tag();
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 30);
    end
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind    = kind_e'(kind_o);
      got.data    = data_byte_o;
      got.stream  = stream_index_o;
      got.pts     = pts_o;
      got.key     = keyframe_o;
      got.is_last = last_byte_o;
      got.vpres   = video_present_o;
      got.apres   = audio_present_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d", cycle_cnt);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= Limit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_file_header();
    test_av_tags();
    test_empty_payload();
    test_short_tags();
    test_other_types();
    test_backpressure();
    test_drain_pause();
    test_random_stream();

    pause_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ftd_pkg.sv
src/flv_tag_deframer.sv
verif/tb_top.sv
